[rtl/bdlp_pkg.sv]
package bdlp_pkg;

  // Stream widths, fields packed from bit 0 and filled up to whole bytes
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 8;
  localparam int unsigned NowW      = 32;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_MS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_MS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE        = 2'd2;

  localparam logic [CfgDataW-1:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [CfgDataW-1:0] LONG_PRESS_MS_RST = 16'd2000;

  // One poll item as taken from the input stream
  typedef struct packed {
    logic [NowW-1:0] now_ms;
    logic            pin_level;
    logic            ack_press;
    logic            ack_long;
    logic            clear_events;
  } bdlp_item_t;

  // Single-bit debounce state
  typedef struct packed {
    logic started;
    logic stable_level;
    logic candidate_level;
    logic long_reported;
    logic press_flag;
    logic long_flag;
  } bdlp_flags_t;

  // One result item
  typedef struct packed {
    logic long_event;
    logic press_event;
    logic is_pressed;
  } bdlp_res_t;

  // Active configuration
  typedef struct packed {
    logic [CfgDataW-1:0] debounce_ms;
    logic [CfgDataW-1:0] long_press_ms;
    logic                enable;
  } bdlp_cfg_t;

endpackage

[rtl/bdlp_step.sv]
module bdlp_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  bdlp_pkg::bdlp_item_t  item_i,
  input  bdlp_pkg::bdlp_cfg_t   cfg_i,
  input  bdlp_pkg::bdlp_flags_t flags_i,
  input  logic [TIME_BITS-1:0]  cand_since_i,
  input  logic [TIME_BITS-1:0]  press_since_i,
  output bdlp_pkg::bdlp_flags_t flags_o,
  output logic [TIME_BITS-1:0]  cand_since_o,
  output logic [TIME_BITS-1:0]  press_since_o,
  output bdlp_pkg::bdlp_res_t   res_o
);
  import bdlp_pkg::*;

  localparam int unsigned NowKeep = (TIME_BITS < NowW) ? TIME_BITS : NowW;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] cand_elapsed;
  logic [TIME_BITS-1:0] press_elapsed;
  logic                 pressed;
  bdlp_flags_t          f;

  // Timestamp cut or widened to the time width
  always_comb begin
    now_t = '0;
    now_t[NowKeep-1:0] = item_i.now_ms[NowKeep-1:0];
  end

  assign pressed = ~item_i.pin_level;

  // Clear, then initialise or poll, then report, then acknowledge
  always_comb begin
    f             = flags_i;
    cand_since_o  = cand_since_i;
    press_since_o = press_since_i;
    cand_elapsed  = '0;
    press_elapsed = '0;

    if (item_i.clear_events) begin
      f.press_flag    = 1'b0;
      f.long_flag     = 1'b0;
      f.long_reported = 1'b0;
    end

    if (!f.started) begin
      f.stable_level    = pressed;
      f.candidate_level = pressed;
      cand_since_o      = now_t;
      press_since_o     = now_t;
      f.press_flag      = 1'b0;
      f.long_flag       = 1'b0;
      f.long_reported   = 1'b0;
      f.started         = 1'b1;
    end else if (cfg_i.enable) begin
      // level change restarts the candidate timer
      if (pressed != f.candidate_level) begin
        f.candidate_level = pressed;
        cand_since_o      = now_t;
      end
      cand_elapsed = now_t - cand_since_o;
      if (f.candidate_level != f.stable_level &&
          cand_elapsed >= TIME_BITS'(cfg_i.debounce_ms)) begin
        f.stable_level  = f.candidate_level;
        f.long_reported = 1'b0;
        if (f.candidate_level) begin
          press_since_o = now_t;
          f.press_flag  = 1'b1;
        end
      end
      press_elapsed = now_t - press_since_o;
      if (f.stable_level && !f.long_reported &&
          press_elapsed >= TIME_BITS'(cfg_i.long_press_ms)) begin
        f.long_reported = 1'b1;
        f.long_flag     = 1'b1;
      end
    end

    res_o.is_pressed  = f.stable_level;
    res_o.press_event = f.press_flag;
    res_o.long_event  = f.long_flag;

    if (item_i.ack_press) f.press_flag = 1'b0;
    if (item_i.ack_long)  f.long_flag  = 1'b0;

    flags_o = f;
  end

endmodule

[rtl/button_debounce_long_press.sv]
// Button debouncer with long-press detection.
//
// Input stream: one poll item per beat, tdata = {clear_events, ack_long,
// ack_press, pin_level (active low), now_ms[31:0]}, MSB first. Every item
// gives exactly one result on the output stream: tdata = {long_event,
// press_event, is_pressed}. The first item after reset only loads the levels
// from the pin and raises no event.
// The configuration port writes debounce_ms (index 0), long_press_ms (1) and
// enable (2); writes are meant only while no item is in flight.
// A result is valid once its item has passed the input register and then the
// result register. Throughput: one item per cycle while the receiver does not
// stall, set by the combinational state update between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; tready falls only when both are full.
// Reset clears the state and loads the register defaults 50, 2000 and 1.
// Timestamps are kept modulo 2^TIME_BITS.
module button_debounce_long_press #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // now_ms[31:0], pin_level, ack_press, ack_long, clear_events, zero fill
  input  logic [bdlp_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // Output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // is_pressed, press_event, long_event, zero fill
  output logic [bdlp_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bdlp_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import bdlp_pkg::*;

  logic                 in_valid_q;
  bdlp_item_t           in_item_q;
  logic                 out_valid_q;
  bdlp_res_t            out_res_q;
  bdlp_cfg_t            cfg_q;
  bdlp_flags_t          flags_q;
  logic [TIME_BITS-1:0] cand_since_q;
  logic [TIME_BITS-1:0] press_since_q;

  bdlp_flags_t          flags_d;
  logic [TIME_BITS-1:0] cand_since_d;
  logic [TIME_BITS-1:0] press_since_d;
  bdlp_res_t            res_d;
  logic                 advance;
  logic                 in_take;

  // Handshake: item moves to the result register when that slot is free or drains
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.now_ms       <= s_axis_tdata_i[NowW-1:0];
      in_item_q.pin_level    <= s_axis_tdata_i[NowW];
      in_item_q.ack_press    <= s_axis_tdata_i[NowW+1];
      in_item_q.ack_long     <= s_axis_tdata_i[NowW+2];
      in_item_q.clear_events <= s_axis_tdata_i[NowW+3];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg_q.long_press_ms <= LONG_PRESS_MS_RST;
      cfg_q.enable        <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_wdata_i;
        CFG_LONG_PRESS_MS: cfg_q.long_press_ms <= cfg_wdata_i;
        CFG_ENABLE:        cfg_q.enable        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Next state and result for the registered item
  bdlp_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .item_i        (in_item_q),
    .cfg_i         (cfg_q),
    .flags_i       (flags_q),
    .cand_since_i  (cand_since_q),
    .press_since_i (press_since_q),
    .flags_o       (flags_d),
    .cand_since_o  (cand_since_d),
    .press_since_o (press_since_d),
    .res_o         (res_d)
  );

  // Debounce state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '0;
      cand_since_q  <= '0;
      press_since_q <= '0;
    end else if (advance) begin
      flags_q       <= flags_d;
      cand_since_q  <= cand_since_d;
      press_since_q <= press_since_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutTdataW-3)'(0), out_res_q.long_event,
                            out_res_q.press_event, out_res_q.is_pressed};

  // Checks
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  a_adv_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> flags_q.started)
    else $error("state not started after an item");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q) && $stable(cand_since_q) && $stable(press_since_q))
    else $error("debounce state changed without an item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled while a register is free");

  a_reported_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.long_reported |-> flags_q.started)
    else $error("long press marked before start");

endmodule

[verif/tb_button_debounce_long_press.sv]
`timescale 1ns / 1ps

module tb_button_debounce_long_press;
  import bdlp_pkg::*;

  localparam int unsigned GAP_MAX      = 17;
  localparam int unsigned HOLD_AT      = 300;    // result count that starts the long stall
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned IDLE_CYCLES  = 4;      // longer than the pass through both registers
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned PRINT_MAX    = 50;

  // Index outside the register map; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 2'd3;

  typedef enum logic [1:0] {ROW_POLL, ROW_CFG} row_kind_e;

  // One directed step; ctl = {clear_events, ack_long, ack_press, pin_level}
  // res = {long_event, press_event, is_pressed}, used only when fixed is set
  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_val;
    logic [NowW-1:0]     now_ms;
    logic [3:0]          ctl;
    logic                fixed;
    logic [2:0]          res;
  } plan_row_t;

  localparam int unsigned NUM_ROWS = 24;
  localparam plan_row_t PLAN [NUM_ROWS] = '{
    // first item loads the released level, no event
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'hFFFF_FFF0, 4'b0001, 1'b1, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'hFFFF_FFFF, 4'b0000, 1'b0, 3'b000},
    // debounce measured across the timestamp wrap: 49 ms, then 50 ms
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0030, 4'b0000, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0031, 4'b0000, 1'b0, 3'b000},
    // bounce while pressed, press acknowledged
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0040, 4'b0011, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0041, 4'b0000, 1'b0, 3'b000},
    // long press: just short of and exactly at the threshold
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_07F0, 4'b0000, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0801, 4'b0000, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0900, 4'b0100, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0A00, 4'b0000, 1'b0, 3'b000},
    // clear re-arms the long event during the same press
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0A00, 4'b1000, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0A01, 4'b1111, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'hFFFF_FFFF, 4'b0001, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0000, 4'b0001, 1'b0, 3'b000},
    // zero times: press and long press on the same poll
    '{ROW_CFG,  CFG_DEBOUNCE_MS, 16'd0, 32'h0,         4'b0000, 1'b0, 3'b000},
    '{ROW_CFG,  CFG_LONG_PRESS_MS, 16'd0, 32'h0,       4'b0000, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0005, 4'b0000, 1'b1, 3'b111},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0005, 4'b0111, 1'b0, 3'b000},
    // disabled: level frozen, clear and acks still act
    '{ROW_CFG,  CFG_ENABLE,      16'd0, 32'h0,         4'b0000, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0064, 4'b1000, 1'b1, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'hFFFF_FFFF, 4'b1111, 1'b0, 3'b000},
    // unmapped index ignored, then enable again
    '{ROW_CFG,  CFG_UNMAPPED,    16'hFFFF, 32'h0,      4'b0000, 1'b0, 3'b000},
    '{ROW_CFG,  CFG_ENABLE,      16'd1, 32'h0,         4'b0000, 1'b0, 3'b000},
    '{ROW_POLL, CFG_DEBOUNCE_MS, 16'd0, 32'h0000_0065, 4'b0000, 1'b0, 3'b000}
  };

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  // now_ms[31:0], pin_level, ack_press, ack_long, clear_events, zero fill
  logic [InTdataW-1:0]  s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  // is_pressed, press_event, long_event, zero fill
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;

  button_debounce_long_press DUT (.*);

  // Predictor state
  bdlp_cfg_t       cfg_q;
  bdlp_flags_t     btn;
  logic [NowW-1:0] cand_since;
  logic [NowW-1:0] press_since;
  bdlp_res_t       res_due [$];

  logic            quiet;      // no gaps or stalls on either side
  logic [NowW-1:0] sim_ms;     // running timestamp of the random part
  int unsigned     n_errors;
  int unsigned     n_results;
  int unsigned     cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL button_debounce_long_press");
      $finish;
    end
  end

  // One poll of the debouncer; updates the predicted state, returns the result
  function automatic bdlp_res_t debounce_poll(bdlp_item_t it);
    logic            pressed;
    logic [NowW-1:0] since_cand;
    logic [NowW-1:0] since_press;
    bdlp_res_t       r;
    pressed = ~it.pin_level;
    if (it.clear_events) begin
      btn.press_flag    = 1'b0;
      btn.long_flag     = 1'b0;
      btn.long_reported = 1'b0;
    end
    if (!btn.started) begin
      btn.stable_level    = pressed;
      btn.candidate_level = pressed;
      cand_since          = it.now_ms;
      press_since         = it.now_ms;
      btn.press_flag      = 1'b0;
      btn.long_flag       = 1'b0;
      btn.long_reported   = 1'b0;
      btn.started         = 1'b1;
    end else if (cfg_q.enable) begin
      if (pressed != btn.candidate_level) begin
        btn.candidate_level = pressed;
        cand_since          = it.now_ms;
      end
      since_cand = it.now_ms - cand_since;
      if (btn.candidate_level != btn.stable_level && since_cand >= cfg_q.debounce_ms) begin
        btn.stable_level  = btn.candidate_level;
        btn.long_reported = 1'b0;
        if (btn.stable_level) begin
          press_since    = it.now_ms;
          btn.press_flag = 1'b1;
        end
      end
      since_press = it.now_ms - press_since;
      if (btn.stable_level && !btn.long_reported && since_press >= cfg_q.long_press_ms) begin
        btn.long_reported = 1'b1;
        btn.long_flag     = 1'b1;
      end
    end
    r.is_pressed  = btn.stable_level;
    r.press_event = btn.press_flag;
    r.long_event  = btn.long_flag;
    // acknowledges act after reporting
    if (it.ack_press) btn.press_flag = 1'b0;
    if (it.ack_long) btn.long_flag = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic got, logic want);
    if (n_errors < PRINT_MAX) begin
      $display("[%0t] mismatch on %s: got %0b, expected %0b (result %0d)",
               $time, field, got, want, n_results);
    end
    n_errors++;
  endtask

  task automatic check_result(bdlp_res_t got);
    bdlp_res_t want;
    if (res_due.size() == 0) begin
      report_mismatch("unexpected result", 1'b1, 1'b0);
    end else begin
      want = res_due.pop_front();
      if (got.is_pressed != want.is_pressed)
        report_mismatch("is_pressed", got.is_pressed, want.is_pressed);
      if (got.press_event != want.press_event)
        report_mismatch("press_event", got.press_event, want.press_event);
      if (got.long_event != want.long_event)
        report_mismatch("long_event", got.long_event, want.long_event);
    end
  endtask

  // Offer one poll item; called and returns at a falling edge
  task automatic send_poll(bdlp_item_t it, logic fixed, bdlp_res_t res);
    int unsigned gap;
    bdlp_res_t   due;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i = {{(InTdataW - NowW - 4){1'b0}}, it.clear_events, it.ack_long,
                      it.ack_press, it.pin_level, it.now_ms};
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    due = debounce_poll(it);
    res_due.push_back(fixed ? res : due);
    @(negedge clk_i);
  endtask

  // Let every pending result come out before touching the registers
  task automatic wait_idle();
    s_axis_tvalid_i = 1'b0;
    while (res_due.size() != 0) @(negedge clk_i);
    repeat (IDLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_DEBOUNCE_MS:   cfg_q.debounce_ms   = val;
      CFG_LONG_PRESS_MS: cfg_q.long_press_ms = val;
      CFG_ENABLE:        cfg_q.enable        = val[0];
      default: ;
    endcase
  endtask

  // Random button activity: a level held for a while, bounce after each flip,
  // random acks and clears, and now and then a jump to any timestamp
  task automatic run_phase(logic [CfgDataW-1:0] db, logic [CfgDataW-1:0] lp, logic en,
                           int unsigned step_max, int unsigned hold_max, int unsigned n,
                           logic wrap, logic q);
    int unsigned hold_left;
    int unsigned bounce_left;
    logic        level_up;
    logic [31:0] rnd;
    bdlp_item_t  it;
    wait_idle();
    cfg_write(CFG_DEBOUNCE_MS, db);
    cfg_write(CFG_LONG_PRESS_MS, lp);
    cfg_write(CFG_ENABLE, {{(CfgDataW - 1){1'b0}}, en});
    quiet = q;
    if (wrap) sim_ms = 32'hFFFF_F000 - $urandom_range(0, 255);
    level_up    = 1'b1;
    hold_left   = 0;
    bounce_left = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (hold_left == 0) begin
        level_up    = ~level_up;
        hold_left   = $urandom_range(1, hold_max);
        bounce_left = $urandom_range(0, 4);
      end
      hold_left--;
      rnd          = $urandom;
      sim_ms       = sim_ms + $urandom_range(0, step_max);
      it.pin_level = level_up;
      if (bounce_left > 0) begin
        it.pin_level = rnd[0];
        bounce_left--;
      end
      it.ack_press    = (rnd[3:2] == 2'b00);
      it.ack_long     = (rnd[5:4] == 2'b00);
      it.clear_events = (rnd[9:6] == 4'b0000);
      if (rnd[14:10] == 5'b00000) sim_ms = $urandom;
      it.now_ms = sim_ms;
      send_poll(it, 1'b0, '0);
    end
    quiet = 1'b0;
  endtask

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    n_results       = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (n_results == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      check_result(bdlp_res_t'(m_axis_tdata_o[2:0]));
      n_results++;
      @(negedge clk_i);
    end
  end

  // Stimulus
  initial begin
    bdlp_item_t it;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_DEBOUNCE_MS;
    cfg_wdata_i     = '0;
    quiet           = 1'b0;
    n_errors        = 0;
    sim_ms          = '0;
    cfg_q           = '{DEBOUNCE_MS_RST, LONG_PRESS_MS_RST, 1'b1};
    btn             = '0;
    cand_since      = '0;
    press_since     = '0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed steps
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(PLAN[r].cfg_idx, PLAN[r].cfg_val);
      end else begin
        it.now_ms = PLAN[r].now_ms;
        {it.clear_events, it.ack_long, it.ack_press, it.pin_level} = PLAN[r].ctl;
        send_poll(it, PLAN[r].fixed, bdlp_res_t'(PLAN[r].res));
      end
    end

    // Random phases: debounce, long press, enable, step, hold, items, wrap, quiet
    run_phase(16'd20,    16'd300,   1'b1, 8,     80, 200, 1'b0, 1'b0);
    run_phase(16'd0,     16'd0,     1'b1, 3,     10, 150, 1'b0, 1'b1);
    run_phase(16'hFFFF,  16'hFFFF,  1'b1, 20000, 40, 150, 1'b0, 1'b0);
    run_phase(16'd7,     16'd50,    1'b0, 6,     20, 80,  1'b0, 1'b0);
    run_phase(16'd10,    16'd60,    1'b1, 6,     40, 200, 1'b1, 1'b0);
    run_phase(16'd1,     16'd1,     1'b1, 2,     6,  120, 1'b0, 1'b0);
    run_phase(DEBOUNCE_MS_RST, LONG_PRESS_MS_RST, 1'b1, 100, 60, 130, 1'b0, 1'b0);

    // Drain
    s_axis_tvalid_i = 1'b0;
    while (res_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("PASS button_debounce_long_press");
    end else begin
      $display("FAIL button_debounce_long_press");
    end
    $finish;
  end

endmodule
